// ----- rtl/perc_pkg.sv -----
// percent codec shared package: command type, escape phase enum, character constants
// and the character classification and hex helper functions
// depends on nothing
package perc_pkg;

    // decode escape progress
    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } t_esc_phase;

    // one queued command from front to back
    typedef struct packed {
        logic       prefix;   // emit the file prefix first
        logic       hex_esc;  // emit '%' and two hex digits of data
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    // character codes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    // byte positions within one expanded command
    localparam int         POS_W    = 4;
    localparam logic [3:0] POS_MAIN = 4'd8;
    localparam logic [3:0] POS_HI   = 4'd9;
    localparam logic [3:0] POS_LO   = 4'd10;

    // "file:///"
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h66;
            3'd1:    c = 8'h69;
            3'd2:    c = 8'h6C;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h3A;
            default: c = 8'h2F;
        endcase
        return c;
    endfunction

    // uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = {4'h3, n};
        end else begin
            c = 8'h37 + {4'h0, n};
        end
        return c;
    endfunction

    // unreserved and reserved characters go through unescaped
    function automatic logic is_passthrough(input logic [7:0] c);
        logic p;
        p = c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                      8'h2D, 8'h5F, 8'h2E, 8'h7E, 8'h21, 8'h2A, 8'h27,
                      8'h28, 8'h29, 8'h3B, 8'h3A, 8'h40, 8'h26, 8'h3D,
                      8'h2B, 8'h24, 8'h2C, 8'h2F, 8'h3F, 8'h23, 8'h5B,
                      8'h5D};
        return p;
    endfunction

    // letters count from ten, digits as usual, anything else keeps its code
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h41:8'h5A]}) begin
            v = c - 8'h37;
        end else if (c inside {[8'h61:8'h7A]}) begin
            v = c - 8'h57;
        end else if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else begin
            v = c;
        end
        return v;
    endfunction

endpackage

// ----- rtl/perc_front.sv -----
// percent codec front end: takes input bytes, tracks string and escape state,
// and turns each byte into at most one command for the back end
// depends on perc_pkg
module perc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_in_byte,
    input  logic             i_in_last,
    output logic             o_push,
    output perc_pkg::t_cmd   o_cmd,
    input  logic             i_full
);
    import perc_pkg::*;

    logic       r_mode, n_mode;
    logic       r_at_start, n_at_start;
    t_esc_phase r_phase, n_phase;
    logic [3:0] r_high, n_high;

    logic       accept;
    logic [7:0] enc_byte;
    logic [7:0] dig;

    assign o_in_ready = !i_full && !i_cfg_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign enc_byte   = (i_in_byte == CH_BSLASH) ? CH_SLASH : i_in_byte;
    assign dig        = digit_value(i_in_byte);

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_at_start = r_at_start;
        n_phase    = r_phase;
        n_high     = r_high;
        if (i_cfg_valid) begin
            n_mode     = i_cfg_data;
            n_at_start = 1'b1;
            n_phase    = ESC_NONE;
            n_high     = 4'h0;
        end else if (accept) begin
            n_at_start = i_in_last;
            if (!r_mode) begin
                n_phase = ESC_NONE;
            end else begin
                case (r_phase)
                    ESC_NONE: begin
                        if (i_in_byte == CH_PERCENT && !i_in_last) begin
                            n_phase = ESC_HIGH;
                        end
                    end
                    ESC_HIGH: begin
                        n_high  = dig[3:0];
                        n_phase = i_in_last ? ESC_NONE : ESC_LOW;
                    end
                    default: n_phase = ESC_NONE;
                endcase
            end
        end
    end

    // command out
    always_comb begin
        o_push = 1'b0;
        o_cmd  = '0;
        if (accept) begin
            if (!r_mode) begin
                o_push        = 1'b1;
                o_cmd.prefix  = r_at_start;
                o_cmd.hex_esc = !is_passthrough(enc_byte);
                o_cmd.data    = enc_byte;
                o_cmd.last    = i_in_last;
            end else begin
                case (r_phase)
                    ESC_NONE: begin
                        if (i_in_byte != CH_PERCENT) begin
                            o_push     = 1'b1;
                            o_cmd.data = i_in_byte;
                            o_cmd.last = i_in_last;
                        end else if (i_in_last) begin
                            o_push     = 1'b1;
                            o_cmd.last = 1'b1;
                            o_cmd.bad  = 1'b1;
                        end
                    end
                    ESC_HIGH: begin
                        if (i_in_last) begin
                            o_push     = 1'b1;
                            o_cmd.last = 1'b1;
                            o_cmd.bad  = 1'b1;
                        end
                    end
                    ESC_LOW: begin
                        o_push     = 1'b1;
                        o_cmd.data = {r_high, 4'h0} + dig;
                        o_cmd.last = i_in_last;
                    end
                    default: o_push = 1'b0;
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_at_start <= 1'b1;
            r_phase    <= ESC_NONE;
            r_high     <= 4'h0;
        end else begin
            r_mode     <= n_mode;
            r_at_start <= n_at_start;
            r_phase    <= n_phase;
            r_high     <= n_high;
        end
    end

    // a mode write leaves a clean string start
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_at_start && r_phase == ESC_NONE))
        else $error("state not cleared after mode write");

    // encode mode never leaves an escape pending
    a_enc_no_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_mode && !i_cfg_valid) |=> (r_phase == ESC_NONE))
        else $error("escape pending in encode mode");

    // a bad escape command always closes the string
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.bad) |-> (o_cmd.last && r_mode))
        else $error("bad escape not at string end");

endmodule

// ----- rtl/perc_queue.sv -----
// percent codec command queue: small register fifo between front and back end
// depends on nothing
module perc_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_MAX);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_MAX) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_MAX) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // the front end only pushes when there is room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    // count never passes the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("queue count out of range");

endmodule

// ----- rtl/perc_back.sv -----
// percent codec back end: expands one command into prefix, plain or escaped
// bytes and holds each result in an output register
// depends on perc_pkg
module perc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  perc_pkg::t_cmd   i_q_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic             o_last,
    output logic             o_bad
);
    import perc_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] eff_pos;
    logic             final_pos;
    logic             load;
    logic [7:0]       sel_byte;
    logic             r_valid, n_valid;
    logic [7:0]       r_byte;
    logic             r_last, r_bad;

    // position inside the current command; commands without prefix start at the main byte
    assign eff_pos   = i_q_cmd.prefix ? r_pos : r_pos + POS_MAIN;
    assign final_pos = i_q_cmd.hex_esc ? (eff_pos == POS_LO) : (eff_pos == POS_MAIN);
    assign load      = i_q_valid && (!r_valid || i_ready);
    assign o_pop     = load && final_pos;

    // byte selection
    always_comb begin
        case (eff_pos)
            POS_MAIN: sel_byte = i_q_cmd.hex_esc ? CH_PERCENT : i_q_cmd.data;
            POS_HI:   sel_byte = hex_char(i_q_cmd.data[7:4]);
            POS_LO:   sel_byte = hex_char(i_q_cmd.data[3:0]);
            default:  sel_byte = prefix_char(eff_pos[2:0]);
        endcase
    end

    // next step and output valid
    always_comb begin
        n_pos   = r_pos;
        n_valid = r_valid;
        if (load) begin
            n_pos   = final_pos ? '0 : r_pos + 1'b1;
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= final_pos && i_q_cmd.last;
            r_bad  <= final_pos && i_q_cmd.bad;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_bad   = r_bad;

    // a flagged result closes its string
    a_bad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad) |-> o_last)
        else $error("bad flag without last");

    // step counter stays inside one expansion
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LO)
        else $error("step counter out of range");

    // mid-command the queue head stays put
    a_hold_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> i_q_valid)
        else $error("command lost mid expansion");

endmodule

// ----- rtl/percent_codec_core.sv -----
// percent codec top level: percent encoding with file prefix, or escape decoding
// a taken request goes to the command queue, then its result to the output register;
// throughput one request a cycle for single byte results while the output is ready and
// the queue has room; escapes and prefixes expand one byte a cycle, which sets the rate
// the command queue lets the input side run ahead by its depth
// synchronous active-low reset: mode encode, string start, no escape, queue and output empty
module percent_codec_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // mode register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,      // mode: 0 encode, 1 decode
    // input bytes
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] in_byte
    input  logic       i_s_axis_tlast,  // end_of_string
    // result bytes
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [7:0] out_byte
    output logic       o_m_axis_tlast,  // last_out
    output logic       o_m_axis_tuser   // [0] bad_escape
);
    import perc_pkg::*;

    logic               push, full, pop, q_valid;
    t_cmd               push_cmd, head_cmd;
    logic [CMD_W-1:0]   head_bits;

    assign o_cfg_ready = 1'b1;
    assign head_cmd    = t_cmd'(head_bits);

    // byte classification and escape tracking
    perc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_byte   (i_s_axis_tdata),
        .i_in_last   (i_s_axis_tlast),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_full      (full)
    );

    // command queue
    perc_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (head_bits)
    );

    // expansion and output register
    perc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_byte    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast),
        .o_bad     (o_m_axis_tuser)
    );

endmodule
